// ----- rtl/lz4bd_pkg.sv -----
`timescale 1ns / 1ps
package lz4bd_pkg;

    localparam int WINDOW_BYTES_DEF = 65536;
    localparam int LANE_BYTES_DEF   = 8;
    localparam int MIN_MATCH        = 4;
    localparam int LAST_LITERALS    = 5;
    localparam int LIM_W            = 31;
    localparam int CNT_W            = 4;
    localparam int STAT_W           = 3;
    localparam int DATA_W           = 64;

    localparam logic CFG_OUT_LIMIT = 1'b0;
    localparam logic CFG_CHECKS_ON = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_COPY      = 3'd1;
    localparam logic [STAT_W-1:0] ST_DONE      = 3'd2;
    localparam logic [STAT_W-1:0] ST_BAD_OFF   = 3'd3;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 3'd4;
    localparam logic [STAT_W-1:0] ST_TRUNCATED = 3'd5;
    localparam logic [STAT_W-1:0] ST_BYTE_BUSY = 3'd6;

    typedef enum logic [3:0] {
        PH_TOKEN,
        PH_LIT_EXT,
        PH_LIT,
        PH_OFF_LO,
        PH_OFF_HI,
        PH_MATCH_EXT,
        PH_COPY,
        PH_DONE,
        PH_BAD_OFF,
        PH_OVER,
        PH_TRUNC
    } phase_t;

    typedef struct packed {
        logic [LIM_W-1:0]  total;
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  count;
        logic [DATA_W-1:0] data;
    } lz4bd_res_t;

    function automatic logic is_terminal(phase_t ph);
        return (ph == PH_DONE) || (ph == PH_BAD_OFF) || (ph == PH_OVER) || (ph == PH_TRUNC);
    endfunction

    function automatic logic [STAT_W-1:0] status_of(phase_t ph);
        logic [STAT_W-1:0] s;
        case (ph)
            PH_COPY:    s = ST_COPY;
            PH_DONE:    s = ST_DONE;
            PH_BAD_OFF: s = ST_BAD_OFF;
            PH_OVER:    s = ST_OVERFLOW;
            PH_TRUNC:   s = ST_TRUNCATED;
            default:    s = ST_OK;
        endcase
        return s;
    endfunction

    function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

// ----- rtl/lz4bd_ram.sv -----
`timescale 1ns / 1ps
module lz4bd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/lz4bd_core.sv -----
`timescale 1ns / 1ps
module lz4bd_core
    import lz4bd_pkg::*;
#(
    parameter int WINDOW_BYTES = WINDOW_BYTES_DEF,
    parameter int LANE_BYTES   = LANE_BYTES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_addr,
    input  logic [LIM_W-1:0] cfg_wdata,
    input  logic             go,
    input  logic             mode,
    input  logic [7:0]       in_byte,
    input  logic             in_last,
    output logic             busy,
    output logic             res_valid,
    output lz4bd_res_t       res
);

    localparam int AW = $clog2(WINDOW_BYTES);

    phase_t            phase_reg, phase_next;
    logic [3:0]        tok_reg, tok_next;
    logic [31:0]       run_reg, run_next;
    logic [15:0]       off_reg, off_next;
    logic [31:0]       bo_reg, bo_next;
    logic [LIM_W-1:0]  lim_reg, lim_next;
    logic              chk_reg, chk_next;
    logic              busy_reg, busy_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [AW-1:0]     src_reg, src_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic              fwd_reg, fwd_next;
    logic [7:0]        fwd_data_reg, fwd_data_next;

    logic              we;
    logic [AW-1:0]     waddr, raddr;
    logic [7:0]        wdata, rdata, cbyte;
    logic [CNT_W-1:0]  n0;
    logic [31:0]       room, lim32, nm;
    logic              finish;

    lz4bd_ram #(.WIDTH(8), .DEPTH(WINDOW_BYTES)) u_hist (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    function automatic phase_t lits_end(logic last, logic chk, logic [31:0] bo,
                                        logic [31:0] lim);
        if (chk)
            return last ? PH_DONE : PH_OFF_LO;
        return (bo >= lim) ? PH_DONE : PH_OFF_LO;
    endfunction

    function automatic phase_t lits_start(logic [31:0] n, logic last, logic chk,
                                          logic [31:0] bo, logic [31:0] lim);
        if (chk && (({1'b0, bo} + {1'b0, n}) > {1'b0, lim}))
            return PH_OVER;
        if (n == 32'd0)
            return lits_end(last, chk, bo, lim);
        return (chk && last) ? PH_TRUNC : PH_LIT;
    endfunction

    function automatic phase_t match_start(logic [31:0] n, logic last, logic chk,
                                           logic [31:0] bo, logic [31:0] lim);
        if (chk)
        begin
            if (({2'b0, bo} + {2'b0, n} + 34'(LAST_LITERALS)) > {2'b0, lim})
                return PH_OVER;
            if (last)
                return PH_TRUNC;
        end
        return PH_COPY;
    endfunction

    assign lim32 = {1'b0, lim_reg};
    assign room  = (bo_reg < lim32) ? (lim32 - bo_reg) : 32'd0;
    assign cbyte = fwd_reg ? fwd_data_reg : rdata;
    assign busy  = busy_reg;

    always_comb
    begin
        n0 = (run_reg < 32'(LANE_BYTES)) ? run_reg[CNT_W-1:0] : CNT_W'(LANE_BYTES);
        if (!chk_reg && (room < {28'b0, n0}))
        begin
            n0 = room[CNT_W-1:0];
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        tok_next      = tok_reg;
        run_next      = run_reg;
        off_next      = off_reg;
        bo_next       = bo_reg;
        lim_next      = lim_reg;
        chk_next      = chk_reg;
        busy_next     = busy_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        src_next      = src_reg;
        acc_next      = acc_reg;
        we            = 1'b0;
        wdata         = in_byte;
        waddr         = bo_reg[AW-1:0];
        raddr         = src_reg;
        res_valid     = 1'b0;
        res.data      = '0;
        res.count     = '0;
        res.status    = ST_OK;
        finish        = 1'b0;
        nm            = 32'd0;

        if (cfg_we)
        begin
            if (cfg_addr == CFG_OUT_LIMIT)
                lim_next = cfg_wdata;
            else
                chk_next = cfg_wdata[0];
        end

        if (busy_reg)
        begin
            we       = 1'b1;
            wdata    = cbyte;
            bo_next  = bo_reg + 32'd1;
            acc_next = acc_reg | ({56'b0, cbyte} << {idx_reg[2:0], 3'b000});
            idx_next = idx_reg + 1'b1;
            src_next = src_reg + 1'b1;
            raddr    = src_reg + 1'b1;
            if (idx_reg + 1'b1 == cnt_reg)
            begin
                busy_next = 1'b0;
                finish    = 1'b1;
                nm        = {28'b0, cnt_reg};
                res.data  = acc_next;
                res.count = cnt_reg;
            end
        end
        else if (go)
        begin
            res_valid = 1'b1;
            if (is_terminal(phase_reg))
            begin
                phase_next = phase_reg;
            end
            else if (mode)
            begin
                if (phase_reg == PH_COPY)
                begin
                    if (n0 == '0)
                    begin
                        finish = 1'b1;
                    end
                    else
                    begin
                        busy_next = 1'b1;
                        res_valid = 1'b0;
                        cnt_next  = n0;
                        idx_next  = '0;
                        acc_next  = '0;
                        src_next  = bo_reg[AW-1:0] - off_reg[AW-1:0];
                        raddr     = bo_reg[AW-1:0] - off_reg[AW-1:0];
                    end
                end
            end
            else if (phase_reg == PH_COPY)
            begin
                res.status = ST_BYTE_BUSY;
            end
            else if (!chk_reg && (bo_reg >= lim32))
            begin
                phase_next = PH_DONE;
            end
            else
            begin
                case (phase_reg)
                    PH_TOKEN:
                    begin
                        tok_next = in_byte[3:0];
                        if (in_byte[7:4] == 4'hF)
                        begin
                            run_next   = 32'd15;
                            phase_next = (chk_reg && in_last) ? PH_TRUNC : PH_LIT_EXT;
                        end
                        else
                        begin
                            run_next   = {28'b0, in_byte[7:4]};
                            phase_next = lits_start({28'b0, in_byte[7:4]}, in_last,
                                                    chk_reg, bo_reg, lim32);
                        end
                    end
                    PH_LIT_EXT:
                    begin
                        run_next = sat_add(run_reg, {24'b0, in_byte});
                        if (in_byte != 8'hFF)
                            phase_next = lits_start(run_next, in_last, chk_reg, bo_reg, lim32);
                        else if (chk_reg && in_last)
                            phase_next = PH_TRUNC;
                    end
                    PH_LIT:
                    begin
                        we        = 1'b1;
                        bo_next   = bo_reg + 32'd1;
                        run_next  = run_reg - 32'd1;
                        res.data  = {56'b0, in_byte};
                        res.count = CNT_W'(1);
                        if (!chk_reg && (bo_next >= lim32))
                            phase_next = PH_DONE;
                        else if (run_next == 32'd0)
                            phase_next = lits_end(in_last, chk_reg, bo_next, lim32);
                        else if (chk_reg && in_last)
                            phase_next = PH_TRUNC;
                    end
                    PH_OFF_LO:
                    begin
                        off_next   = {8'b0, in_byte};
                        phase_next = (chk_reg && in_last) ? PH_TRUNC : PH_OFF_HI;
                    end
                    PH_OFF_HI:
                    begin
                        off_next = {in_byte, off_reg[7:0]};
                        if (chk_reg && ((off_next == 16'd0) || ({16'b0, off_next} > bo_reg)
                            || ({16'b0, off_next} > 32'(WINDOW_BYTES))))
                        begin
                            phase_next = PH_BAD_OFF;
                        end
                        else if (tok_reg == 4'hF)
                        begin
                            run_next   = 32'd15;
                            phase_next = (chk_reg && in_last) ? PH_TRUNC : PH_MATCH_EXT;
                        end
                        else
                        begin
                            run_next   = {28'b0, tok_reg} + 32'(MIN_MATCH);
                            phase_next = match_start(run_next, in_last, chk_reg, bo_reg, lim32);
                        end
                    end
                    PH_MATCH_EXT:
                    begin
                        run_next = sat_add(run_reg, {24'b0, in_byte});
                        if (in_byte != 8'hFF)
                        begin
                            run_next   = sat_add(run_next, 32'(MIN_MATCH));
                            phase_next = match_start(run_next, in_last, chk_reg, bo_reg, lim32);
                        end
                        else if (chk_reg && in_last)
                        begin
                            phase_next = PH_TRUNC;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end

        if (finish)
        begin
            res_valid = 1'b1;
            run_next  = run_reg - nm;
            if (!chk_reg && (bo_next >= lim32))
                phase_next = PH_DONE;
            else if (run_next == 32'd0)
                phase_next = PH_TOKEN;
        end

        if (res.status != ST_BYTE_BUSY)
            res.status = status_of(phase_next);
        res.total = bo_next[LIM_W-1:0];

        fwd_next      = we && (raddr == waddr);
        fwd_data_next = wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TOKEN;
            tok_reg   <= '0;
            run_reg   <= '0;
            off_reg   <= '0;
            bo_reg    <= '0;
            lim_reg   <= '0;
            chk_reg   <= 1'b1;
            busy_reg  <= 1'b0;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            fwd_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            tok_reg   <= tok_next;
            run_reg   <= run_next;
            off_reg   <= off_next;
            bo_reg    <= bo_next;
            lim_reg   <= lim_next;
            chk_reg   <= chk_next;
            busy_reg  <= busy_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            fwd_reg   <= fwd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg      <= src_next;
        acc_reg      <= acc_next;
        fwd_data_reg <= fwd_data_next;
    end

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (idx_reg < cnt_reg))
        else $error("copy byte index past chunk size");

    a_no_go_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !go)
        else $error("item taken during a copy");

    a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && finish) |=> !busy_reg)
        else $error("copy engine still busy after last byte");

    a_copy_phase: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (phase_reg == PH_COPY))
        else $error("copy running outside copy phase");

endmodule

// ----- rtl/lz4_block_decompressor_top.sv -----
`timescale 1ns / 1ps
// Channel   Dir  Handshake          Payload
// s_axis    in   s_tvalid/s_tready  s_tdata: mode, in_byte; s_tlast: in_last
// m_axis    out  m_tvalid/m_tready  m_tdata: out_data, out_count, out_total; m_tuser: status
// cfg       in   cfg_we             cfg_addr, cfg_wdata
//
// A byte item's result is registered and shown on m_axis the cycle after the item is taken.
// A continue item copying n bytes (n up to LANE_BYTES) holds off input while it copies,
// one history read per cycle on the single read port of the history RAM.
// Reset clears control state; history contents stay undefined until written.
// A full output register holds off input only when it is not being taken.
module lz4_block_decompressor_top
    import lz4bd_pkg::*;
#(
    parameter int WINDOW_BYTES = WINDOW_BYTES_DEF,
    parameter int LANE_BYTES   = LANE_BYTES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_addr,
    input  logic [LIM_W-1:0] cfg_wdata,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [15:0]      s_tdata,   // [0] mode, [8:1] in_byte, [15:9] zero
    input  logic             s_tlast,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [103:0]     m_tdata,   // [63:0] out_data, [67:64] out_count,
                                        // [98:68] out_total, [103:99] zero
    output logic [STAT_W-1:0] m_tuser   // status
);

    logic       busy, go, res_valid;
    lz4bd_res_t res;
    lz4bd_res_t out_reg, out_next;
    logic       out_valid_reg, out_valid_next;

    lz4bd_core #(.WINDOW_BYTES(WINDOW_BYTES), .LANE_BYTES(LANE_BYTES)) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .go        (go),
        .mode      (s_tdata[0]),
        .in_byte   (s_tdata[8:1]),
        .in_last   (s_tlast),
        .busy      (busy),
        .res_valid (res_valid),
        .res       (res)
    );

    assign s_tready = !busy && (!out_valid_reg || m_tready);
    assign go       = s_tvalid && s_tready;

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (res_valid)
        begin
            out_next       = res;
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_reg.total, out_reg.count, out_reg.data};
    assign m_tuser  = out_reg.status;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !res_valid)
        else $error("result overwrote a held item");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.count <= CNT_W'(LANE_BYTES)))
        else $error("byte count above lane size");

    a_go_result: assert property (@(posedge clk) disable iff (!rst_n)
        (go && !s_tdata[0]) |-> res_valid)
        else $error("byte item gave no result");

endmodule
